// ===== rtl/cps_pkg.sv =====
// Shared types and constants for the complex peak search block.
// No dependencies; every file but the two interfaces imports this package.
package cps_pkg;

    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int THRESH_W    = 24;
    localparam int BIN_CFG_W   = 17;
    localparam int BIN_OUT_W   = 16;
    localparam int PHASE_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int GUARD_BITS  = 8;
    localparam int ANGLE_W     = 27;
    localparam int ANGLE_PI    = 16777216;
    localparam int GAIN_W      = 24;
    localparam int GAIN_FRAC   = 24;
    localparam int PHASE_ROUND = 256;
    localparam int PHASE_LSB   = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [GAIN_W-1:0]    GAIN_Q24  = 24'd10188014;
    localparam logic [COUNT_W-1:0]   COUNT_MAX = 17'h1FFFF;
    localparam logic [BIN_CFG_W-1:0] RECORD_LENGTH_RST = 17'h10000;

    localparam logic [22:0] ATAN_UNITS [24] = '{
        23'd4194304, 23'd2476042, 23'd1308273, 23'd664100, 23'd333339, 23'd166832,
        23'd83436,   23'd41721,   23'd20861,   23'd10430,  23'd5215,   23'd2608,
        23'd1304,    23'd652,     23'd326,     23'd163,    23'd81,     23'd41,
        23'd20,      23'd10,      23'd5,       23'd3,      23'd1,      23'd1
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD     = 2'd0,
        CFG_RECORD_LENGTH = 2'd1,
        CFG_BEGIN_BIN     = 2'd2,
        CFG_END_MARGIN    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                 first;
        logic                 last;
        logic [BIN_OUT_W-1:0] bin;
    } t_tag;

endpackage

// ===== rtl/cps_in_if.sv =====
// Sample channel: one I/Q pair and a record start mark per beat.
// Depends on nothing.
interface cps_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_phase;
    logic signed [SAMPLE_BITS-1:0] quadrature;
    logic                          record_start;

    modport source (output valid, output in_phase, output quadrature, output record_start,
                    input ready);
    modport sink   (input valid, input in_phase, input quadrature, input record_start,
                    output ready);
endinterface

// ===== rtl/cps_out_if.sv =====
// Report channel: one peak report per beat.
// Depends on nothing.
interface cps_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] peak_magnitude;
    logic [15:0]            peak_bin;
    logic signed [15:0]     peak_phase;
    logic [16:0]            event_count;

    modport source (output valid, output peak_magnitude, output peak_bin,
                    output peak_phase, output event_count, input ready);
    modport sink   (input valid, input peak_magnitude, input peak_bin,
                    input peak_phase, input event_count, output ready);
endinterface

// ===== rtl/cps_front.sv =====
// Front end: bin counting, window classification and the sample queue.
// Depends on cps_pkg and cps_in_if.
module cps_front #(
    parameter int MAX_RECORD  = 65536,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    cps_in_if.sink                            i_smp,
    input  logic [cps_pkg::BIN_CFG_W-1:0]     i_record_length,
    input  logic [cps_pkg::BIN_CFG_W-1:0]     i_begin_bin,
    input  logic [cps_pkg::BIN_CFG_W-1:0]     i_end_margin,
    input  logic                              i_pop,
    output logic                              o_valid,
    output logic signed [SAMPLE_BITS-1:0]     o_x,
    output logic signed [SAMPLE_BITS-1:0]     o_y,
    output cps_pkg::t_tag                     o_tag
);
    import cps_pkg::*;

    localparam int CW   = $clog2(MAX_RECORD + 1);
    localparam int CMPW = ((CW > BIN_CFG_W) ? CW : BIN_CFG_W) + 1;
    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_RECORD);

    logic [CW-1:0]   r_bin;
    logic [CW-1:0]   n_bin;
    logic            r_seen;

    logic signed [SAMPLE_BITS-1:0] r_qx [QUEUE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_qy [QUEUE_DEPTH];
    t_tag                          r_qt [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]           r_wp;
    logic [QUEUE_AW-1:0]           r_rp;
    logic [QUEUE_AW:0]             r_qcnt;

    logic [CMPW-1:0] len;
    logic [CMPW-1:0] margin;
    logic [CMPW-1:0] win_end;
    logic [CW-1:0]   bin;
    logic [CMPW-1:0] bin_e;
    logic            win;
    logic            acc;
    logic            push;
    logic            pop;
    t_tag            tag;

    always_comb begin
        margin  = CMPW'(i_end_margin);
        len     = (CMPW'(i_record_length) > MAX_C) ? MAX_C : CMPW'(i_record_length);
        win_end = (margin < len) ? (len - margin) : '0;
        bin     = i_smp.record_start ? '0 : r_bin;
        bin_e   = CMPW'(bin);
        win     = (bin_e < MAX_C) && (bin_e >= CMPW'(i_begin_bin)) && (bin_e < win_end);
        n_bin   = (bin_e < MAX_C) ? (bin + CW'(1)) : bin;
        tag.first = i_smp.record_start || !r_seen;
        tag.last  = ((bin_e + CMPW'(1)) == win_end);
        tag.bin   = bin_e[BIN_OUT_W-1:0];
    end

    assign i_smp.ready = (r_qcnt != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign acc  = i_smp.valid && i_smp.ready;
    assign push = acc && win;
    assign pop  = i_pop && (r_qcnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin  <= '0;
            r_seen <= 1'b0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_qcnt <= '0;
        end else begin
            if (acc) begin
                r_bin <= n_bin;
                if (win) begin
                    r_seen <= 1'b1;
                end else if (i_smp.record_start) begin
                    r_seen <= 1'b0;
                end
            end
            if (push) begin
                r_wp <= r_wp + QUEUE_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QUEUE_AW'(1);
            end
            if (push && !pop) begin
                r_qcnt <= r_qcnt + (QUEUE_AW+1)'(1);
            end else if (pop && !push) begin
                r_qcnt <= r_qcnt - (QUEUE_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_qx[r_wp] <= i_smp.in_phase;
            r_qy[r_wp] <= i_smp.quadrature;
            r_qt[r_wp] <= tag;
        end
    end

    assign o_valid = (r_qcnt != '0);
    assign o_x     = r_qx[r_rp];
    assign o_y     = r_qy[r_rp];
    assign o_tag   = r_qt[r_rp];

endmodule

// ===== rtl/cps_cordic.sv =====
// Pipelined vectoring CORDIC with gain correction: I/Q to magnitude and phase.
// Depends on cps_pkg.
module cps_cordic #(
    parameter int SAMPLE_BITS   = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [SAMPLE_BITS-1:0]       i_x,
    input  logic signed [SAMPLE_BITS-1:0]       i_y,
    input  cps_pkg::t_tag                       i_tag,
    output logic                                o_valid,
    output logic [SAMPLE_BITS-1:0]              o_mag,
    output logic signed [cps_pkg::PHASE_W-1:0]  o_phase,
    output cps_pkg::t_tag                       o_tag
);
    import cps_pkg::*;

    localparam int N  = CORDIC_STAGES;
    localparam int W  = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int XW = W - 1;
    localparam int L  = XW / 2;
    localparam int HW = XW - L;
    localparam int PW = XW + GAIN_W + 1;
    localparam int SH = GAIN_FRAC + GUARD_BITS;
    localparam int MW = PW - SH;

    logic [N:0]               r_v;
    logic [N:0]               r_zr;
    logic signed [W-1:0]      r_x [0:N];
    logic signed [W-1:0]      r_y [0:N];
    logic signed [ANGLE_W-1:0] r_z [0:N];
    t_tag                     r_t [0:N];

    logic                     r_v1;
    logic                     r_zr1;
    logic [L+GAIN_W-1:0]      r_plo;
    logic [HW+GAIN_W-1:0]     r_phi;
    logic [PHASE_W-1:0]       r_ph1;
    t_tag                     r_t1;

    logic                     r_v2;
    logic [SAMPLE_BITS-1:0]   r_mag;
    logic [PHASE_W-1:0]       r_ph2;
    t_tag                     r_t2;

    logic signed [W-1:0]       xe;
    logic signed [W-1:0]       ye;
    logic signed [W-1:0]       xs;
    logic signed [W-1:0]       ys;
    logic signed [ANGLE_W-1:0] z0;
    logic [XW-1:0]             xc;
    logic [ANGLE_W-1:0]        zs;
    logic [PW-1:0]             sum;
    logic [MW-1:0]             m;

    always_comb begin
        xe = W'(i_x);
        ye = W'(i_y);
        if (i_x[SAMPLE_BITS-1]) begin
            xs = -xe;
            ys = -ye;
            z0 = i_y[SAMPLE_BITS-1] ? -ANGLE_W'(ANGLE_PI) : ANGLE_W'(ANGLE_PI);
        end else begin
            xs = xe;
            ys = ye;
            z0 = '0;
        end
        xc  = r_x[N][W-1] ? '0 : r_x[N][XW-1:0];
        zs  = r_z[N] + ANGLE_W'(PHASE_ROUND);
        sum = PW'({r_phi, {L{1'b0}}}) + PW'(r_plo) + (PW'(1) << (SH - 1));
        m   = sum[PW-1:SH];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[N-1:0], i_valid};
            r_v1 <= r_v[N];
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]  <= xs <<< GUARD_BITS;
            r_y[0]  <= ys <<< GUARD_BITS;
            r_z[0]  <= z0;
            r_zr[0] <= (i_x == '0) && (i_y == '0);
            r_t[0]  <= i_tag;
            for (int k = 0; k < N; k++) begin
                r_zr[k+1] <= r_zr[k];
                r_t[k+1]  <= r_t[k];
                if (!r_y[k][W-1]) begin
                    r_x[k+1] <= r_x[k] + (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] - (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] + ANGLE_W'(ATAN_UNITS[k]);
                end else begin
                    r_x[k+1] <= r_x[k] - (r_y[k] >>> k);
                    r_y[k+1] <= r_y[k] + (r_x[k] >>> k);
                    r_z[k+1] <= r_z[k] - ANGLE_W'(ATAN_UNITS[k]);
                end
            end
            r_plo <= xc[L-1:0] * GAIN_Q24;
            r_phi <= xc[XW-1:L] * GAIN_Q24;
            r_ph1 <= r_zr[N] ? '0 : zs[PHASE_LSB+PHASE_W-1:PHASE_LSB];
            r_zr1 <= r_zr[N];
            r_t1  <= r_t[N];
            if (r_zr1) begin
                r_mag <= '0;
            end else if (|m[MW-1:SAMPLE_BITS]) begin
                r_mag <= '1;
            end else begin
                r_mag <= m[SAMPLE_BITS-1:0];
            end
            r_ph2 <= r_ph1;
            r_t2  <= r_t1;
        end
    end

    assign o_valid = r_v2;
    assign o_mag   = r_mag;
    assign o_phase = r_ph2;
    assign o_tag   = r_t2;

endmodule

// ===== rtl/cps_accum.sv =====
// Back end: running peak and event count, report register and stall control.
// Depends on cps_pkg and cps_out_if.
module cps_accum #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [SAMPLE_BITS-1:0]              i_mag,
    input  logic signed [cps_pkg::PHASE_W-1:0]  i_phase,
    input  cps_pkg::t_tag                       i_tag,
    input  logic [cps_pkg::THRESH_W-1:0]        i_threshold,
    output logic                                o_en,
    cps_out_if.source                           o_pk
);
    import cps_pkg::*;

    localparam int TW = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

    logic [SAMPLE_BITS-1:0] r_best;
    logic [BIN_OUT_W-1:0]   r_bbin;
    logic [PHASE_W-1:0]     r_bph;
    logic [COUNT_W-1:0]     r_cnt;

    logic                   r_ov;
    logic [SAMPLE_BITS-1:0] r_omag;
    logic [BIN_OUT_W-1:0]   r_obin;
    logic [PHASE_W-1:0]     r_oph;
    logic [COUNT_W-1:0]     r_ocnt;

    logic                   take;
    logic [SAMPLE_BITS-1:0] n_best;
    logic [BIN_OUT_W-1:0]   n_bbin;
    logic [PHASE_W-1:0]     n_bph;
    logic [COUNT_W-1:0]     base;
    logic [COUNT_W-1:0]     n_cnt;
    logic                   upd;

    assign o_en = !r_ov || o_pk.ready;
    assign upd  = o_en && i_valid;

    always_comb begin
        take   = i_tag.first || (i_mag > r_best);
        n_best = take ? i_mag : r_best;
        n_bbin = take ? i_tag.bin : r_bbin;
        n_bph  = take ? i_phase : r_bph;
        base   = i_tag.first ? '0 : r_cnt;
        n_cnt  = ((TW'(i_mag) > TW'(i_threshold)) && (base != COUNT_MAX)) ?
                 (base + COUNT_W'(1)) : base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (o_en) begin
            r_ov <= i_valid && i_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd) begin
            r_best <= n_best;
            r_bbin <= n_bbin;
            r_bph  <= n_bph;
            r_cnt  <= n_cnt;
            if (i_tag.last) begin
                r_omag <= n_best;
                r_obin <= n_bbin;
                r_oph  <= n_bph;
                r_ocnt <= n_cnt;
            end
        end
    end

    assign o_pk.valid          = r_ov;
    assign o_pk.peak_magnitude = r_omag;
    assign o_pk.peak_bin       = r_obin;
    assign o_pk.peak_phase     = r_oph;
    assign o_pk.event_count    = r_ocnt;

endmodule

// ===== rtl/complex_peak_search_top.sv =====
// Top level of the complex peak search: configuration registers and the
// front end, CORDIC and back end. Depends on cps_pkg, cps_in_if, cps_out_if.
//
// Usage: samples enter on i_smp, one I/Q pair per beat, with record_start
// set on bin 0 of each record. The four configuration registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only
// while the block is idle, as the block does not enforce this. At the last
// bin of the search window one report beat leaves on o_pk with the peak
// magnitude, its bin and phase and the count of samples above the threshold;
// records with an empty window give no report. Throughput: one sample per
// cycle while o_pk does not stall. The sample at the last window bin passes
// the queue, the pre-rotation register (loaded straight from the queue),
// one register per CORDIC stage, two gain-correction stages and the report
// register. Samples outside the window are dropped by the front end at once.
// Reset clears the bin counter, the queue and the report valid, and loads
// the register defaults (record length 65536, everything else zero).
// When o_pk stalls with a report pending, the whole back end holds; the
// four-entry queue keeps absorbing samples until full, then i_smp.ready drops.
module complex_peak_search_top #(
    parameter int MAX_RECORD    = 65536,
    parameter int SAMPLE_BITS   = 24,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cps_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    cps_in_if.sink                             i_smp,
    cps_out_if.source                          o_pk
);
    import cps_pkg::*;

    logic [THRESH_W-1:0]  r_threshold;
    logic [BIN_CFG_W-1:0] r_record_length;
    logic [BIN_CFG_W-1:0] r_begin_bin;
    logic [BIN_CFG_W-1:0] r_end_margin;

    logic                          en;
    logic                          q_valid;
    logic signed [SAMPLE_BITS-1:0] q_x;
    logic signed [SAMPLE_BITS-1:0] q_y;
    t_tag                          q_tag;
    logic                          c_valid;
    logic [SAMPLE_BITS-1:0]        c_mag;
    logic signed [PHASE_W-1:0]     c_phase;
    t_tag                          c_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= '0;
            r_record_length <= RECORD_LENGTH_RST;
            r_begin_bin     <= '0;
            r_end_margin    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD:     r_threshold     <= i_cfg_data[THRESH_W-1:0];
                CFG_RECORD_LENGTH: r_record_length <= i_cfg_data[BIN_CFG_W-1:0];
                CFG_BEGIN_BIN:     r_begin_bin     <= i_cfg_data[BIN_CFG_W-1:0];
                CFG_END_MARGIN:    r_end_margin    <= i_cfg_data[BIN_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cps_front #(
        .MAX_RECORD  (MAX_RECORD),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_smp           (i_smp),
        .i_record_length (r_record_length),
        .i_begin_bin     (r_begin_bin),
        .i_end_margin    (r_end_margin),
        .i_pop           (en),
        .o_valid         (q_valid),
        .o_x             (q_x),
        .o_y             (q_y),
        .o_tag           (q_tag)
    );

    cps_cordic #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (q_valid),
        .i_x     (q_x),
        .i_y     (q_y),
        .i_tag   (q_tag),
        .o_valid (c_valid),
        .o_mag   (c_mag),
        .o_phase (c_phase),
        .o_tag   (c_tag)
    );

    cps_accum #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (c_valid),
        .i_mag       (c_mag),
        .i_phase     (c_phase),
        .i_tag       (c_tag),
        .i_threshold (r_threshold),
        .o_en        (en),
        .o_pk        (o_pk)
    );

endmodule

// ===== rtl/cps_check.sv =====
// Port-level checks for complex_peak_search_top, bound to the top level.
// Depends on cps_pkg.
module cps_check #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_peak_magnitude,
    input logic [16:0]            i_event_count
);
    import cps_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("report beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_peak_magnitude) && $stable(i_event_count))
        else $error("report payload changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid && i_in_ready)
        else $error("outputs not quiet after reset");

    a_ready_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_in_valid && i_in_ready |=> i_in_ready)
        else $error("input ready dropped without an accepted beat");

endmodule

bind complex_peak_search_top cps_check #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cps_check (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_smp.valid),
    .i_in_ready       (i_smp.ready),
    .i_out_valid      (o_pk.valid),
    .i_out_ready      (o_pk.ready),
    .i_peak_magnitude (o_pk.peak_magnitude),
    .i_event_count    (o_pk.event_count)
);

// ===== bench/tb.sv =====
// Testbench for complex_peak_search_top: drives I/Q sample records and checks every
// peak report against a CORDIC peak tracker kept in the bench.
// Depends on cps_pkg, cps_in_if, cps_out_if and the RTL of the block.
module tb;
    import cps_pkg::*;

    localparam int MAX_RECORD    = 65536;
    localparam int SAMPLE_BITS   = 24;
    localparam int CORDIC_STAGES = 16;
    localparam int SETTLE_CYCLES = CORDIC_STAGES + 4 + QUEUE_DEPTH + 12;
    localparam int SMP_MAX       = 8388607;
    localparam int SMP_MIN       = -8388608;
    localparam int MAG_MAX       = 11863283;
    localparam int EVENT_SAT     = 131071;
    localparam longint GAIN_RECIP = 64'sd10188014;
    localparam longint GAIN_HALF  = 64'sd2147483648;
    localparam longint MAG_SAT    = 64'sd16777215;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] in_phase;
        logic signed [SAMPLE_BITS-1:0] quadrature;
        logic                          record_start;
    } sample_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] peak_magnitude;
        logic [15:0]            peak_bin;
        logic signed [15:0]     peak_phase;
        logic [16:0]            event_count;
    } report_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cps_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    cps_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) pk_if ();

    complex_peak_search_top #(
        .MAX_RECORD   (MAX_RECORD),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_smp     (smp_if),
        .o_pk      (pk_if)
    );

    int unsigned cfg_threshold = 0;
    int unsigned cfg_length    = MAX_RECORD;
    int unsigned cfg_begin     = 0;
    int unsigned cfg_margin    = 0;

    int unsigned            bin_next    = 0;
    int unsigned            above_cnt   = 0;
    logic [SAMPLE_BITS-1:0] best_mag    = '0;
    logic [15:0]            best_bin    = '0;
    logic [15:0]            best_ph     = '0;
    bit                     window_open = 1'b0;

    report_t expected_reports[$];

    int mismatches   = 0;
    int samples_sent = 0;
    int records_sent = 0;
    int reports_seen = 0;
    int settings_cnt = 0;
    bit idle_on      = 1'b1;
    int amp_bits     = 23;

    always #4 i_clk = ~i_clk;

    function automatic longint arc_step(input int k);
        case (k)
            0:  return 4194304;
            1:  return 2476042;
            2:  return 1308273;
            3:  return 664100;
            4:  return 333339;
            5:  return 166832;
            6:  return 83436;
            7:  return 41721;
            8:  return 20861;
            9:  return 10430;
            10: return 5215;
            11: return 2608;
            12: return 1304;
            13: return 652;
            14: return 326;
            15: return 163;
            default: return 0;
        endcase
    endfunction

    function automatic void to_polar(input logic signed [SAMPLE_BITS-1:0] i_s,
                                     input logic signed [SAMPLE_BITS-1:0] q_s,
                                     output logic [SAMPLE_BITS-1:0] mag,
                                     output logic [15:0] ph);
        longint x, y, z, dx, dy, m;
        int k;
        x = i_s;
        y = q_s;
        z = 0;
        mag = '0;
        ph = '0;
        if (x == 0 && y == 0) return;
        if (x < 0) begin
            z = (y >= 0) ? ANGLE_PI : -ANGLE_PI;
            x = -x;
            y = -y;
        end
        x = x <<< GUARD_BITS;
        y = y <<< GUARD_BITS;
        for (k = 0; k < CORDIC_STAGES; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (y >= 0) begin
                x = x + dx;
                y = y - dy;
                z = z + arc_step(k);
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - arc_step(k);
            end
        end
        if (x < 0) x = 0;
        m = (x * GAIN_RECIP + GAIN_HALF) >>> 32;
        if (m > MAG_SAT) m = MAG_SAT;
        mag = m[SAMPLE_BITS-1:0];
        m = (z + 256) >>> 9;
        ph = m[15:0];
    endfunction

    function automatic void track_peak(input sample_t s);
        int unsigned bin, span, stop;
        logic [SAMPLE_BITS-1:0] mag;
        logic [15:0] ph;
        if (s.record_start) begin
            bin_next = 0;
            best_mag = '0;
            best_bin = '0;
            best_ph = '0;
            above_cnt = 0;
            window_open = 1'b0;
        end
        bin = bin_next;
        if (bin_next < MAX_RECORD) bin_next++;
        span = (cfg_length > MAX_RECORD) ? MAX_RECORD : cfg_length;
        stop = (cfg_margin < span) ? span - cfg_margin : 0;
        if (bin >= MAX_RECORD || bin < cfg_begin || bin >= stop) return;
        to_polar(s.in_phase, s.quadrature, mag, ph);
        if (!window_open || mag > best_mag) begin
            best_mag = mag;
            best_bin = bin[15:0];
            best_ph = ph;
            window_open = 1'b1;
        end
        if (mag > cfg_threshold && above_cnt < EVENT_SAT) above_cnt++;
        if (bin + 1 == stop)
            expected_reports.push_back(report_t'{best_mag, best_bin, best_ph, above_cnt[16:0]});
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic sample_t mk(input int i_v, input int q_v, input bit start);
        sample_t s;
        s.in_phase = i_v[SAMPLE_BITS-1:0];
        s.quadrature = q_v[SAMPLE_BITS-1:0];
        s.record_start = start;
        return s;
    endfunction

    function automatic int extreme_value();
        case ($urandom_range(0, 4))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return 0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic sample_t random_sample(input sample_t prev);
        sample_t s;
        logic signed [31:0] w;
        int r;
        r = $urandom_range(0, 99);
        s.record_start = 1'b0;
        if (r < 10) begin
            s = prev;
        end else if (r < 15) begin
            s.in_phase = prev.quadrature;
            s.quadrature = prev.in_phase;
        end else if (r < 20) begin
            s.in_phase = '0;
            s.quadrature = '0;
        end else if (r < 28) begin
            s = mk(extreme_value(), extreme_value(), 1'b0);
        end else begin
            w = $urandom;
            w = w >>> (31 - amp_bits);
            s.in_phase = w[SAMPLE_BITS-1:0];
            w = $urandom;
            w = w >>> (31 - amp_bits);
            s.quadrature = w[SAMPLE_BITS-1:0];
        end
        s.record_start = 1'b0;
        return s;
    endfunction

    task automatic send_sample(input sample_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.in_phase <= s.in_phase;
        smp_if.quadrature <= s.quadrature;
        smp_if.record_start <= s.record_start;
        do @(posedge i_clk); while (!smp_if.ready);
        track_peak(s);
        samples_sent++;
        if (s.record_start) records_sent++;
    endtask

    task automatic drain();
        smp_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input int unsigned thr, input int unsigned len,
                                  input int unsigned beg, input int unsigned margin);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_THRESHOLD;
        i_cfg_data <= thr[23:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_RECORD_LENGTH;
        i_cfg_data <= len[16:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_BEGIN_BIN;
        i_cfg_data <= beg[16:0];
        @(posedge i_clk);
        i_cfg_idx <= CFG_END_MARGIN;
        i_cfg_data <= margin[16:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_threshold = thr & 32'hFFFFFF;
        cfg_length = len & 32'h1FFFF;
        cfg_begin = beg & 32'h1FFFF;
        cfg_margin = margin & 32'h1FFFF;
        settings_cnt++;
    endtask

    task automatic test_before_record_start();
        apply_settings(0, 4, 0, 0);
        send_sample(mk(0, 0, 1'b0));
        send_sample(mk(SMP_MAX, SMP_MAX, 1'b0));
        send_sample(mk(SMP_MIN, 0, 1'b0));
        send_sample(mk(SMP_MIN, -1, 1'b0));
        drain();
    endtask

    task automatic test_window_edges();
        apply_settings(MAG_MAX, 6, 1, 1);
        send_sample(mk(SMP_MAX, SMP_MAX, 1'b1));
        send_sample(mk(100, 0, 1'b0));
        send_sample(mk(0, 100, 1'b0));
        send_sample(mk(SMP_MIN, SMP_MIN, 1'b0));
        send_sample(mk(SMP_MAX, SMP_MIN, 1'b0));
        send_sample(mk(-1, 1, 1'b0));
        drain();
        apply_settings(0, 3, 0, 0);
        send_sample(mk(0, 0, 1'b1));
        send_sample(mk(0, -1, 1'b0));
        send_sample(mk(1, 0, 1'b0));
        drain();
    endtask

    task automatic test_empty_windows();
        apply_settings(0, 0, 0, 0);
        send_sample(mk(SMP_MAX, 0, 1'b1));
        send_sample(mk(0, SMP_MAX, 1'b0));
        drain();
        apply_settings(32'hFFFFFF, 5, 0, MAX_RECORD);
        send_sample(mk(SMP_MIN, SMP_MAX, 1'b1));
        send_sample(mk(5, -5, 1'b0));
        drain();
        apply_settings(0, 5, MAX_RECORD, 0);
        send_sample(mk(-7, 7, 1'b1));
        send_sample(mk(SMP_MAX, SMP_MIN, 1'b0));
        drain();
    endtask

    task automatic test_length_clamp();
        sample_t s, prev;
        int n;
        idle_on = 1'b0;
        amp_bits = 23;
        prev = '0;
        apply_settings(0, 32'h1FFFF, 3, MAX_RECORD - 40);
        for (n = 0; n < 44; n++) begin
            s = random_sample(prev);
            s.record_start = (n == 0);
            send_sample(s);
            prev = s;
        end
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_random_records();
        sample_t s, prev;
        int phase, n, len, beg, margin, rec_items, phase_items;
        int unsigned thr;
        bit first;
        for (phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 2))
                0: amp_bits = 6;
                1: amp_bits = 12;
                default: amp_bits = 23;
            endcase
            n = $urandom_range(0, 99);
            if (phase == 0 || n < 15) len = 1;
            else if (n < 75) len = $urandom_range(2, 24);
            else len = $urandom_range(25, 64);
            beg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len + 2)
                                              : $urandom_range(0, len / 2);
            margin = ($urandom_range(0, 4) == 0) ? $urandom_range(0, len + 2)
                                                 : $urandom_range(0, len / 2);
            if (amp_bits == 23) thr = $urandom_range(0, MAG_MAX);
            else thr = $urandom_range(0, (3 << amp_bits) / 2);
            if (phase == 1) thr = 0;
            idle_on = ($urandom_range(0, 4) != 0);
            apply_settings(thr, len, beg, margin);
            prev = '0;
            phase_items = 0;
            while (phase_items < 120) begin
                rec_items = ($urandom_range(0, 99) < 85) ? len : $urandom_range(1, len + 4);
                first = ($urandom_range(0, 19) != 0);
                for (n = 0; n < rec_items; n++) begin
                    s = random_sample(prev);
                    s.record_start = (n == 0) ? first : ($urandom_range(0, 99) == 0);
                    send_sample(s);
                    prev = s;
                    phase_items++;
                end
            end
            drain();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        int stall;
        pk_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            stall = pick_gap();
            if (stall == 0) begin
                pk_if.ready <= 1'b1;
            end else begin
                pk_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                pk_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        report_t want;
        if (i_rst_n && pk_if.valid && pk_if.ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $error("report beat with no report expected");
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                if (want.peak_magnitude !== pk_if.peak_magnitude) begin
                    $error("peak_magnitude: expected %0d, got %0d",
                           want.peak_magnitude, pk_if.peak_magnitude);
                    mismatches++;
                end
                if (want.peak_bin !== pk_if.peak_bin) begin
                    $error("peak_bin: expected %0d, got %0d", want.peak_bin, pk_if.peak_bin);
                    mismatches++;
                end
                if (want.peak_phase !== pk_if.peak_phase) begin
                    $error("peak_phase: expected %0d, got %0d",
                           want.peak_phase, pk_if.peak_phase);
                    mismatches++;
                end
                if (want.event_count !== pk_if.event_count) begin
                    $error("event_count: expected %0d, got %0d",
                           want.event_count, pk_if.event_count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #8000000;
        $display("FAIL complex_peak_search_top");
        $finish;
    end

    initial begin
        int waited;
        smp_if.valid <= 1'b0;
        smp_if.in_phase <= '0;
        smp_if.quadrature <= '0;
        smp_if.record_start <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_THRESHOLD;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_record_start();
        test_window_edges();
        test_empty_windows();
        test_length_clamp();
        test_random_records();

        smp_if.valid <= 1'b0;
        waited = 0;
        while (expected_reports.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $error("%0d expected reports never arrived", expected_reports.size());
            mismatches += expected_reports.size();
        end
        $display("Sent %0d samples in %0d records under %0d register settings;",
                 samples_sent, records_sent, settings_cnt);
        $display("checked %0d peak reports, %0d field mismatches.", reports_seen, mismatches);
        if (mismatches == 0) begin
            $display("PASS complex_peak_search_top");
        end else begin
            $display("FAIL complex_peak_search_top");
        end
        $finish;
    end

endmodule
